>>> sv/auto_extending_array_store_macros.svh
// Assertion macros for the array store.
// Each macro expects clk_i and rst_ni in the scope of its use.
`ifndef AUTO_EXTENDING_ARRAY_STORE_MACROS_SVH
`define AUTO_EXTENDING_ARRAY_STORE_MACROS_SVH

`ifndef NO_ASSERTIONS

`define AEAS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("aeas check failed");

`define AEAS_ASSERT_NEVER(lbl, expr) \
  `AEAS_ASSERT(lbl, !(expr))

`else

`define AEAS_ASSERT(lbl, prop)

`define AEAS_ASSERT_NEVER(lbl, expr)

`endif

`endif

>>> sv/aeas_pkg.sv
package aeas_pkg;

  localparam int DEF_ARRAY_COUNT = 16;
  localparam int DEF_ARRAY_SIZE  = 1024;

  localparam int CMD_W   = 1;
  localparam int ARR_W   = 4;
  localparam int IDX_W   = 64;
  localparam int TAG_W   = 4;
  localparam int PAY_W   = 64;
  localparam int STAT_W  = 3;
  localparam int CELL_W  = TAG_W + PAY_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 1'b0,
    CMD_READ  = 1'b1
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK           = 3'd0,
    ST_NEG_INDEX    = 3'd1,
    ST_TOO_LARGE    = 3'd2,
    ST_NO_ARRAY     = 3'd3,
    ST_OUT_OF_RANGE = 3'd4
  } status_e;

  typedef struct packed {
    status_e status;
    logic    wr_en;
    logic    rd_ok;
  } dec_t;

endpackage

>>> sv/aeas_cell_mem.sv
module aeas_cell_mem #(
  parameter int DEPTH = aeas_pkg::DEF_ARRAY_COUNT * aeas_pkg::DEF_ARRAY_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr_i,
  input  logic                         wr_en_i,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr_i,
  input  logic [aeas_pkg::CELL_W-1:0]  wr_data_i,
  output logic [aeas_pkg::CELL_W-1:0]  rd_data_o
);

  logic [aeas_pkg::CELL_W-1:0] mem [DEPTH];
  logic [aeas_pkg::CELL_W-1:0] rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // forward a word written in the same cycle
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? wr_data_i : mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

>>> sv/aeas_wbit_mem.sv
module aeas_wbit_mem #(
  parameter int DEPTH = aeas_pkg::DEF_ARRAY_COUNT * aeas_pkg::DEF_ARRAY_SIZE
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  output logic                     rd_data_o,
  output logic                     busy_o
);

  localparam int AW = $clog2(DEPTH);

  logic          mem [DEPTH];
  logic          rd_q;
  logic          busy_q, busy_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          we;
  logic [AW-1:0] wa;
  logic          wd;

  // sweep all bits to zero after reset
  always_comb begin
    busy_d = busy_q;
    clr_d  = clr_q;
    if (busy_q) begin
      clr_d = clr_q + AW'(1);
      if (clr_q == AW'(DEPTH - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b1;
      clr_q  <= '0;
    end else begin
      busy_q <= busy_d;
      clr_q  <= clr_d;
    end
  end

  assign we = busy_q || wr_en_i;
  assign wa = busy_q ? clr_q : wr_addr_i;
  assign wd = !busy_q;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= (wr_en_i && (wr_addr_i == rd_addr_i)) ? 1'b1 : mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;
  assign busy_o    = busy_q;

endmodule

>>> sv/aeas_dir.sv
`include "auto_extending_array_store_macros.svh"

module aeas_dir #(
  parameter int ARRAY_COUNT = aeas_pkg::DEF_ARRAY_COUNT,
  parameter int ARRAY_SIZE  = aeas_pkg::DEF_ARRAY_SIZE
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic [aeas_pkg::CMD_W-1:0]  cmd_i,
  input  logic [aeas_pkg::ARR_W-1:0]  arr_i,
  input  logic [aeas_pkg::IDX_W-1:0]  idx_i,
  output aeas_pkg::dec_t              dec_o
);

  localparam int NW = (ARRAY_COUNT > 1) ? $clog2(ARRAY_COUNT) : 1;
  localparam int IW = $clog2(ARRAY_SIZE);
  localparam int LW = $clog2(ARRAY_SIZE + 1);

  logic          ex_q  [ARRAY_COUNT];
  logic [LW-1:0] len_q [ARRAY_COUNT];

  logic          in_range;
  logic [NW-1:0] a;
  logic          cur_ex;
  logic [LW-1:0] cur_len;
  logic [LW-1:0] new_len;
  logic          idx_neg;
  logic          too_big;
  logic          past_len;
  aeas_pkg::dec_t dec;

  assign in_range = 32'(arr_i) < 32'(ARRAY_COUNT);
  assign a        = NW'(arr_i);
  assign cur_ex   = ex_q[a];
  assign cur_len  = len_q[a];
  assign new_len  = LW'(idx_i[IW-1:0]) + LW'(1);
  assign idx_neg  = idx_i[aeas_pkg::IDX_W-1];
  assign too_big  = idx_i >= aeas_pkg::IDX_W'(ARRAY_SIZE);
  assign past_len = idx_i >= aeas_pkg::IDX_W'(cur_len);

  always_comb begin
    dec.status = aeas_pkg::ST_OK;
    dec.wr_en  = 1'b0;
    dec.rd_ok  = 1'b0;
    unique case (aeas_pkg::cmd_e'(cmd_i))
      aeas_pkg::CMD_WRITE: begin
        if (idx_neg) begin
          dec.status = aeas_pkg::ST_NEG_INDEX;
        end else if (too_big) begin
          dec.status = aeas_pkg::ST_TOO_LARGE;
        end else if (!in_range) begin
          dec.status = aeas_pkg::ST_NO_ARRAY;
        end else begin
          dec.wr_en = 1'b1;
        end
      end
      aeas_pkg::CMD_READ: begin
        if (!in_range || !cur_ex) begin
          dec.status = aeas_pkg::ST_NO_ARRAY;
        end else if (idx_neg || past_len) begin
          dec.status = aeas_pkg::ST_OUT_OF_RANGE;
        end else begin
          dec.rd_ok = 1'b1;
        end
      end
      default: begin
        dec.status = aeas_pkg::ST_OK;
      end
    endcase
  end

  // create the array and grow its length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ARRAY_COUNT; i++) begin
        ex_q[i]  <= 1'b0;
        len_q[i] <= '0;
      end
    end else if (en_i && dec.wr_en) begin
      ex_q[a] <= 1'b1;
      if (new_len > cur_len) begin
        len_q[a] <= new_len;
      end
    end
  end

  assign dec_o = dec;

  `AEAS_ASSERT(a_len_only_when_exists, (en_i && in_range && !cur_ex) |-> (cur_len == '0))
  `AEAS_ASSERT(a_write_sets_exists,
               (en_i && dec.wr_en) |=> ex_q[$past(a)])
  `AEAS_ASSERT_NEVER(a_len_over_size, en_i && in_range && (32'(cur_len) > 32'(ARRAY_SIZE)))

endmodule

>>> sv/auto_extending_array_store.sv
// Channel | Direction | Handshake            | Word
// in      | input     | in_valid_i/in_stall_o | command, array, index, tag, payload
// out     | output    | out_valid_o/out_stall_i | status, read tag, read payload
//
// One word per cycle if out_stall_i is low and no sweep runs; the result is registered after the middle stage.
// Each word reads the cell memory and written-bit memory once through one read port.
// After reset all ARRAY_COUNT*ARRAY_SIZE written bits (16384 by default) are swept clear,
// one per cycle; in_stall_o is high meanwhile.
// A held result stalls the middle stage and then the input.
`include "auto_extending_array_store_macros.svh"

module auto_extending_array_store #(
  parameter int ARRAY_COUNT = aeas_pkg::DEF_ARRAY_COUNT,
  parameter int ARRAY_SIZE  = aeas_pkg::DEF_ARRAY_SIZE
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [aeas_pkg::CMD_W-1:0]   command_i,
  input  logic [aeas_pkg::ARR_W-1:0]   array_number_i,
  input  logic [aeas_pkg::IDX_W-1:0]   cell_index_i,
  input  logic [aeas_pkg::TAG_W-1:0]   value_tag_i,
  input  logic [aeas_pkg::PAY_W-1:0]   value_payload_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [aeas_pkg::STAT_W-1:0]  status_o,
  output logic [aeas_pkg::TAG_W-1:0]   read_tag_o,
  output logic [aeas_pkg::PAY_W-1:0]   read_payload_o
);

  localparam int DEPTH = ARRAY_COUNT * ARRAY_SIZE;
  localparam int AW    = $clog2(DEPTH);
  localparam int IW    = $clog2(ARRAY_SIZE);

  logic                        in_acc;
  logic [AW-1:0]               slot;
  logic                        s1_adv;
  logic                        wbusy;
  logic                        wbit;
  logic [aeas_pkg::CELL_W-1:0] cell_rdata;
  logic                        mem_we;
  aeas_pkg::dec_t              dec;

  logic                        s1_valid_q, s1_valid_d;
  logic [aeas_pkg::CMD_W-1:0]  s1_cmd_q;
  logic [aeas_pkg::ARR_W-1:0]  s1_arr_q;
  logic [aeas_pkg::IDX_W-1:0]  s1_idx_q;
  logic [aeas_pkg::TAG_W-1:0]  s1_tag_q;
  logic [aeas_pkg::PAY_W-1:0]  s1_pay_q;
  logic [AW-1:0]               s1_slot_q;

  logic                        out_valid_q, out_valid_d;
  logic [aeas_pkg::STAT_W-1:0] status_q;
  logic [aeas_pkg::TAG_W-1:0]  rtag_q, rtag_d;
  logic [aeas_pkg::PAY_W-1:0]  rpay_q, rpay_d;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = wbusy || (s1_valid_q && !s1_adv);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign slot       = AW'(array_number_i) * AW'(ARRAY_SIZE) + AW'(cell_index_i[IW-1:0]);
  assign mem_we     = s1_adv && dec.wr_en;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= command_i;
      s1_arr_q  <= array_number_i;
      s1_idx_q  <= cell_index_i;
      s1_tag_q  <= value_tag_i;
      s1_pay_q  <= value_payload_i;
      s1_slot_q <= slot;
    end
  end

  aeas_dir #(
    .ARRAY_COUNT (ARRAY_COUNT),
    .ARRAY_SIZE  (ARRAY_SIZE)
  ) u_dir (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (s1_adv),
    .cmd_i  (s1_cmd_q),
    .arr_i  (s1_arr_q),
    .idx_i  (s1_idx_q),
    .dec_o  (dec)
  );

  aeas_wbit_mem #(
    .DEPTH (DEPTH)
  ) u_wbit (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_acc),
    .rd_addr_i (slot),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_slot_q),
    .rd_data_o (wbit),
    .busy_o    (wbusy)
  );

  aeas_cell_mem #(
    .DEPTH (DEPTH)
  ) u_cell (
    .clk_i     (clk_i),
    .rd_en_i   (in_acc),
    .rd_addr_i (slot),
    .wr_en_i   (mem_we),
    .wr_addr_i (s1_slot_q),
    .wr_data_i ({s1_tag_q, s1_pay_q}),
    .rd_data_o (cell_rdata)
  );

  // drop gap cells and failed reads to zero
  always_comb begin
    rtag_d = '0;
    rpay_d = '0;
    if (dec.rd_ok && wbit) begin
      rtag_d = cell_rdata[aeas_pkg::CELL_W-1:aeas_pkg::PAY_W];
      rpay_d = cell_rdata[aeas_pkg::PAY_W-1:0];
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      status_q <= dec.status;
      rtag_q   <= rtag_d;
      rpay_q   <= rpay_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign read_tag_o     = rtag_q;
  assign read_payload_o = rpay_q;

  `AEAS_ASSERT(a_write_only_ok,
               mem_we |-> (dec.status == aeas_pkg::ST_OK &&
                           s1_cmd_q == aeas_pkg::CMD_WRITE))
  `AEAS_ASSERT(a_fail_reads_zero,
               (out_valid_q && status_q != aeas_pkg::ST_OK) |->
               (rtag_q == '0 && rpay_q == '0))
  `AEAS_ASSERT(a_result_from_stage, $rose(out_valid_q) |-> $past(s1_adv))
  `AEAS_ASSERT_NEVER(a_no_work_in_sweep, wbusy && s1_valid_q)

endmodule
